// ----- hw/rtl/ppw_pkg.sv -----
// shared types, constants and register codes of the peer presence watchdog
package ppw_pkg;

  // timestamp width; differences wrap modulo 2**TimeBits
  localparam int unsigned TimeBits = 48;
  // compare width: wide enough for a timestamp and a 32-bit limit
  localparam int unsigned CmpBits  = (TimeBits > 32) ? TimeBits : 32;
  localparam int unsigned LimBits  = 32;
  localparam int unsigned CntBits  = 3;

  // configuration port
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 32;

  localparam logic [CfgIdxBits-1:0] RegSilenceLimit = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegProbeSpacing = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegBailTime     = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegProbeLimit   = 2'd3;

  // register reset values
  localparam logic [LimBits-1:0] SilenceLimitRst = 32'd1500000;
  localparam logic [LimBits-1:0] ProbeSpacingRst = 32'd500000;
  localparam logic [LimBits-1:0] BailTimeRst     = 32'd1500000;
  localparam logic [CntBits-1:0] ProbeLimitRst   = 3'd3;

  typedef logic [TimeBits-1:0] time_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_FRAME = 2'd1,
    OP_PING  = 2'd2,
    OP_PONG  = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [LimBits-1:0] silence_limit;
    logic [LimBits-1:0] probe_spacing;
    logic [LimBits-1:0] bail_time;
    logic [CntBits-1:0] probe_limit;
  } cfg_t;

  typedef struct packed {
    time_t              last_heard_time;
    time_t              check_start_time;
    time_t              last_probe_time;
    logic [CntBits-1:0] probes_sent;
    logic               check_active;
    logic               lost_flag;
    logic               pong_flag;
  } state_t;

  typedef struct packed {
    logic send_probe;
    logic send_reply;
    logic lost_event;
    logic restored_event;
    logic link_lost;
    logic roundtrip_seen;
  } result_t;

  // link starts lost, everything else cleared
  localparam state_t StateRst = '{
    last_heard_time:  '0,
    check_start_time: '0,
    last_probe_time:  '0,
    probes_sent:      '0,
    check_active:     1'b0,
    lost_flag:        1'b1,
    pong_flag:        1'b0
  };

  // wrapped time difference, widened for comparison against a limit
  function automatic logic [CmpBits-1:0] elapsed(input time_t now, input time_t then);
    time_t diff;
    diff = now - then;
    return CmpBits'(diff);
  endfunction

endpackage

// ----- hw/rtl/ppw_if.sv -----
// valid/ready channel interfaces for event words and result words

interface ppw_in_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic [ppw_pkg::TimeBits-1:0] time_now;

  modport source (output valid, output opcode, output time_now, input ready);
  modport sink   (input valid, input opcode, input time_now, output ready);
endinterface

interface ppw_out_if;
  logic valid;
  logic ready;
  logic send_probe;
  logic send_reply;
  logic lost_event;
  logic restored_event;
  logic link_lost;
  logic roundtrip_seen;

  modport source (output valid, output send_probe, output send_reply, output lost_event,
                  output restored_event, output link_lost, output roundtrip_seen,
                  input ready);
  modport sink   (input valid, input send_probe, input send_reply, input lost_event,
                  input restored_event, input link_lost, input roundtrip_seen,
                  output ready);
endinterface

// ----- hw/rtl/peer_presence_watchdog_core.sv -----
// Peer presence watchdog: takes one event word (tick or peer frame/ping/pong
// with a timestamp) per clock cycle while the result side keeps taking words
// and returns one result word per event. An event is held in an input
// register, then passes the next-state logic (three wrapped timestamp
// subtractions and compares) into the result register. The watchdog state
// is updated as each event moves into the result register, so consecutive
// events see each other's effect. The user must write configuration only
// while the block is idle; the block itself does not enforce this.
module peer_presence_watchdog_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ppw_in_if.sink                          in_if,
  ppw_out_if.source                       out_if,
  input  logic                            cfg_we_i,
  input  logic [ppw_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [ppw_pkg::CfgDataBits-1:0] cfg_data_i
);

  ppw_pkg::cfg_t    cfg;
  ppw_pkg::state_t  state_q, state_d;
  ppw_pkg::result_t result_q, result_d;
  logic             in_valid_q, out_valid_q, out_valid_d, advance;
  logic [1:0]       opcode_q;
  ppw_pkg::time_t   time_now_q;

  ppw_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // handshake: move the held word on when the result register is free
  assign advance     = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || advance;
  assign out_valid_d = advance || (out_valid_q && !out_if.ready);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      opcode_q   <= in_if.opcode;
      time_now_q <= in_if.time_now;
    end
  end

  ppw_eval u_eval (
    .opcode_i   (opcode_q),
    .time_now_i (time_now_q),
    .cfg_i      (cfg),
    .state_i    (state_q),
    .state_o    (state_d),
    .result_o   (result_d)
  );

  // watchdog state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ppw_pkg::StateRst;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.send_probe     = result_q.send_probe;
  assign out_if.send_reply     = result_q.send_reply;
  assign out_if.lost_event     = result_q.lost_event;
  assign out_if.restored_event = result_q.restored_event;
  assign out_if.link_lost      = result_q.link_lost;
  assign out_if.roundtrip_seen = result_q.roundtrip_seen;

endmodule

// ----- hw/rtl/ppw_cfg_regs.sv -----
// configuration registers of the peer presence watchdog
module ppw_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ppw_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [ppw_pkg::CfgDataBits-1:0]  cfg_data_i,
  output ppw_pkg::cfg_t                    cfg_o
);

  ppw_pkg::cfg_t cfg_q, cfg_d;

  // decode the write into the addressed field
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ppw_pkg::RegSilenceLimit: cfg_d.silence_limit = cfg_data_i;
        ppw_pkg::RegProbeSpacing: cfg_d.probe_spacing = cfg_data_i;
        ppw_pkg::RegBailTime:     cfg_d.bail_time     = cfg_data_i;
        ppw_pkg::RegProbeLimit:   cfg_d.probe_limit   = cfg_data_i[ppw_pkg::CntBits-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.silence_limit <= ppw_pkg::SilenceLimitRst;
      cfg_q.probe_spacing <= ppw_pkg::ProbeSpacingRst;
      cfg_q.bail_time     <= ppw_pkg::BailTimeRst;
      cfg_q.probe_limit   <= ppw_pkg::ProbeLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/ppw_eval.sv -----
// next-state and result logic for one event word
module ppw_eval (
  input  logic [1:0]       opcode_i,
  input  ppw_pkg::time_t   time_now_i,
  input  ppw_pkg::cfg_t    cfg_i,
  input  ppw_pkg::state_t  state_i,
  output ppw_pkg::state_t  state_o,
  output ppw_pkg::result_t result_o
);

  logic [ppw_pkg::CmpBits-1:0] el_heard, el_probe, el_check;
  logic [ppw_pkg::CmpBits-1:0] silence_w, spacing_w, bail_w;
  logic [ppw_pkg::CntBits-1:0] probes_eff;
  ppw_pkg::time_t              last_probe_eff;
  logic                        starting, silent, spacing_ok, probe, lose;
  ppw_pkg::opcode_e            op;

  assign op = ppw_pkg::opcode_e'(opcode_i);

  // limits widened to compare width
  assign silence_w = ppw_pkg::CmpBits'(cfg_i.silence_limit);
  assign spacing_w = ppw_pkg::CmpBits'(cfg_i.probe_spacing);
  assign bail_w    = ppw_pkg::CmpBits'(cfg_i.bail_time);

  // a check that starts on this tick sees cleared probe state and zero age
  assign starting       = !state_i.check_active;
  assign probes_eff     = starting ? '0 : state_i.probes_sent;
  assign last_probe_eff = starting ? '0 : state_i.last_probe_time;

  assign el_heard = ppw_pkg::elapsed(time_now_i, state_i.last_heard_time);
  assign el_probe = ppw_pkg::elapsed(time_now_i, last_probe_eff);
  assign el_check = starting ? '0 : ppw_pkg::elapsed(time_now_i, state_i.check_start_time);

  assign silent     = el_heard >= silence_w;
  assign spacing_ok = (probes_eff == '0) || (el_probe >= spacing_w);
  assign probe      = (probes_eff < cfg_i.probe_limit) && spacing_ok;
  assign lose       = !state_i.lost_flag && (el_check >= bail_w);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    unique case (op)
      // tick: silence check, probing and loss detection
      ppw_pkg::OP_TICK: begin
        if (silent) begin
          if (starting) begin
            state_o.check_active     = 1'b1;
            state_o.check_start_time = time_now_i;
            state_o.last_probe_time  = '0;
            state_o.probes_sent      = '0;
          end
          if (probe) begin
            result_o.send_probe     = 1'b1;
            state_o.last_probe_time = time_now_i;
            state_o.probes_sent     = probes_eff + 1'b1;
          end
          if (lose) begin
            state_o.lost_flag   = 1'b1;
            result_o.lost_event = 1'b1;
          end
        end
      end
      // any peer word marks presence
      ppw_pkg::OP_FRAME, ppw_pkg::OP_PING, ppw_pkg::OP_PONG: begin
        state_o.last_heard_time  = time_now_i;
        state_o.check_active     = 1'b0;
        state_o.check_start_time = '0;
        state_o.probes_sent      = '0;
        state_o.lost_flag        = 1'b0;
        result_o.restored_event  = state_i.lost_flag;
        result_o.send_reply      = (op == ppw_pkg::OP_PING);
        if (op == ppw_pkg::OP_PONG) begin
          state_o.pong_flag = 1'b1;
        end
      end
      default: state_o = state_i;
    endcase
    result_o.link_lost      = state_o.lost_flag;
    result_o.roundtrip_seen = state_o.pong_flag;
  end

endmodule

// ----- hw/rtl/ppw_checker.sv -----
// port-level checks on the peer presence watchdog result stream
module ppw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  ppw_out_if.source  out_if
);

  logic out_take;
  logic lost_seen_q, rt_seen_q;

  assign out_take = out_if.valid && out_if.ready;

  // status carried by the last word taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lost_seen_q <= 1'b1;
      rt_seen_q   <= 1'b0;
    end else if (out_take) begin
      lost_seen_q <= out_if.link_lost;
      rt_seen_q   <= out_if.roundtrip_seen;
    end
  end

  // round-trip flag never drops once shown
  a_rt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && rt_seen_q |-> out_if.roundtrip_seen)
    else $error("roundtrip_seen cleared after being set");

  // loss status changes only together with its event
  a_lost_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take |-> ((out_if.link_lost != lost_seen_q) ==
                  (out_if.lost_event || out_if.restored_event)))
    else $error("link_lost changed without a matching event");

  a_lost_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && out_if.lost_event |-> !lost_seen_q && out_if.link_lost)
    else $error("lost_event while the link was already lost");

  a_restored_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && out_if.restored_event |-> lost_seen_q && !out_if.link_lost)
    else $error("restored_event while the link was not lost");

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid &&
      $stable(out_if.send_probe) && $stable(out_if.send_reply) &&
      $stable(out_if.lost_event) && $stable(out_if.restored_event) &&
      $stable(out_if.link_lost) && $stable(out_if.roundtrip_seen))
    else $error("result word changed while stalled");

endmodule

bind peer_presence_watchdog_core ppw_checker u_ppw_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .out_if (out_if)
);
